// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbus frame decoder assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbus frame decoder assertion failed");

`endif

// ===== src/sfd_pkg.sv =====
// Shared types and constants of the S.BUS frame decoder.
// No dependencies; imported by the configuration interface, the controller, the datapath, the core and the testbench.
package sfd_pkg;

    localparam int FRAME_LEN  = 25;
    localparam int SLIDE_LEN  = 24;
    localparam int MARK_POS   = 22;
    localparam int FLAG_POS   = 23;
    localparam int DATA_BYTES = 22;
    localparam int DATA_BITS  = 8 * DATA_BYTES;
    localparam int CHAN_BITS  = 11;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MARKER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FLAGS  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET = 2'd3;

    localparam logic [7:0]           HEADER_RESET = 8'h0F;
    localparam logic [7:0]           MARKER_RESET = 8'h80;
    localparam logic [7:0]           FLAGS_RESET  = 8'h30;
    localparam logic [CHAN_BITS-1:0] OFFSET_RESET = 11'd300;

    typedef logic [7:0] byte_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic shift_byte;   // push the accepted byte into the window
        logic fill_clear;   // aligned frame: restart the fill count
        logic fill_slide;   // misaligned window: keep 24 bytes
        logic load_data;    // copy the channel bytes into the unpack register
        logic advance;      // result taken: move to the next channel
    } sfd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic window_last;  // the next byte completes the window
        logic aligned;      // header and marker bytes match
        logic flag_hit;     // flag byte shares a bit with the mask
        logic last_chan;    // the current channel is the final one
    } sfd_status_t;

endpackage

// ===== src/sfd_rx_if.sv =====
// Receive byte channel of the S.BUS frame decoder.
// Plain valid/ready handshake; no dependencies.
interface sfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/sfd_res_if.sv =====
// Decoded channel result channel of the S.BUS frame decoder.
// Plain valid/ready handshake; no dependencies.
interface sfd_res_if;
    logic               valid;
    logic               ready;
    logic [3:0]         channel_index;
    logic signed [11:0] channel_value;
    logic               last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input last_channel, output ready);
endinterface

// ===== src/sfd_cfg_if.sv =====
// Configuration write channel of the S.BUS frame decoder.
// Depends on sfd_pkg for the index and data widths.
interface sfd_cfg_if
    import sfd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/sfd_ctrl.sv =====
// Controller of the S.BUS frame decoder: collect, check and emit sequencing.
// Depends on sfd_pkg for the command and status structs.
module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  sfd_status_t status,
    output sfd_cmd_t    cmd
);

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_CHECK   = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.shift_byte = 1'b1;
                    if (status.window_last)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (!status.aligned)
                begin
                    cmd.fill_slide = 1'b1;
                    state_next     = ST_COLLECT;
                end
                else
                begin
                    cmd.fill_clear = 1'b1;
                    if (status.flag_hit)
                    begin
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        cmd.load_data = 1'b1;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    if (status.last_chan)
                    begin
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/sfd_datapath.sv =====
// Datapath of the S.BUS frame decoder: byte window, config registers, unpacker.
// Depends on sfd_pkg for constants and the command and status structs.
module sfd_datapath
    import sfd_pkg::*;
#(
    parameter int CHANNELS        = 16,
    parameter int OFFSET_CHANNELS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  byte_t                  rx_byte,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  sfd_cmd_t               cmd,
    output sfd_status_t            status,
    output logic [3:0]             channel_index,
    output logic signed [11:0]     channel_value,
    output logic                   last_channel
);

    byte_t                  win_reg [FRAME_LEN];
    logic [4:0]             fill_reg;
    logic [4:0]             fill_next;
    logic [DATA_BITS-1:0]   data_reg;
    logic [DATA_BITS-1:0]   data_next;
    logic [3:0]             chan_reg;
    logic [3:0]             chan_next;
    byte_t                  header_reg;
    byte_t                  marker_reg;
    byte_t                  flags_reg;
    logic [CHAN_BITS-1:0]   offset_reg;
    logic [11:0]            raw_value;
    logic                   offset_chan;

    // The newest byte always enters at the top, so a slide is simply the next shift.
    always_ff @(posedge clk)
    begin
        if (cmd.shift_byte)
        begin
            for (int k = 0; k < FRAME_LEN - 1; k++)
            begin
                win_reg[k] <= win_reg[k + 1];
            end
            win_reg[FRAME_LEN - 1] <= rx_byte;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        priority if (cmd.fill_clear)
        begin
            fill_next = 5'd0;
        end
        else if (cmd.fill_slide)
        begin
            fill_next = 5'(SLIDE_LEN);
        end
        else if (cmd.shift_byte)
        begin
            fill_next = fill_reg + 5'd1;
        end
    end

    always_comb
    begin
        data_next = data_reg;
        if (cmd.load_data)
        begin
            for (int k = 0; k < DATA_BYTES; k++)
            begin
                data_next[8*k +: 8] = win_reg[k + 1];
            end
        end
        else if (cmd.advance)
        begin
            data_next = data_reg >> CHAN_BITS;
        end
    end

    always_comb
    begin
        chan_next = chan_reg;
        if (cmd.load_data)
        begin
            chan_next = 4'd0;
        end
        else if (cmd.advance)
        begin
            chan_next = chan_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= 5'd0;
            chan_reg   <= 4'd0;
            header_reg <= HEADER_RESET;
            marker_reg <= MARKER_RESET;
            flags_reg  <= FLAGS_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else
        begin
            fill_reg <= fill_next;
            chan_reg <= chan_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_HEADER: header_reg <= cfg_data[7:0];
                    REG_MARKER: marker_reg <= cfg_data[7:0];
                    REG_FLAGS:  flags_reg  <= cfg_data[7:0];
                    REG_OFFSET: offset_reg <= cfg_data;
                endcase
            end
        end
    end

    assign status.window_last = (fill_reg == 5'(SLIDE_LEN));
    assign status.aligned     = (win_reg[0] == header_reg) && (win_reg[MARK_POS] == marker_reg);
    assign status.flag_hit    = |(win_reg[FLAG_POS] & flags_reg);
    assign status.last_chan   = (chan_reg == 4'(CHANNELS - 1));

    // Channel values wrap modulo 4096, matching the two's complement result.
    assign raw_value     = {1'b0, data_reg[CHAN_BITS-1:0]};
    assign offset_chan   = ({1'b0, chan_reg} < 5'(OFFSET_CHANNELS));
    assign channel_value = offset_chan ? signed'(raw_value - {1'b0, offset_reg})
                                       : signed'(raw_value);
    assign channel_index = chan_reg;
    assign last_channel  = status.last_chan;

endmodule

// ===== src/sbus_frame_decoder_core.sv =====
// S.BUS frame decoder: byte requests fill a 25-byte window, one per cycle outside the
// check and emit states. A completing byte is checked in the next cycle; a misaligned
// or dropped window stalls the byte side only while it is checked. A good frame then
// offers CHANNELS results one per cycle while the result side is ready, from the emit
// state that follows the check; bytes are held off until the last result is taken.
// Reset (rst_n, asynchronous, active low) clears control state and loads register defaults.
module sbus_frame_decoder_core
    import sfd_pkg::*;
#(
    parameter int CHANNELS        = 16,
    parameter int OFFSET_CHANNELS = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    sfd_rx_if.sink    rx,
    sfd_res_if.source result,
    sfd_cfg_if.sink   cfg
);

    // Command and status bundles between the controller and the datapath.
    sfd_cmd_t    cmd;
    sfd_status_t status;

    // Configuration writes are always taken and land at once. The sender only writes while
    // no frame is being checked or emitted; the block itself does not enforce this.
    assign cfg.ready = 1'b1;

    // The controller walks through collect, check and emit. Only the collect
    // state takes byte requests, and only the emit state offers results.
    sfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the window as a shift line, so a misaligned window
    // slides by one simply on the next byte. A good frame is copied into a
    // 176-bit unpack register that drops eleven bits for every result taken.
    sfd_datapath #(
        .CHANNELS        (CHANNELS),
        .OFFSET_CHANNELS (OFFSET_CHANNELS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (rx.rx_byte),
        .cfg_write     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .cmd           (cmd),
        .status        (status),
        .channel_index (result.channel_index),
        .channel_value (result.channel_value),
        .last_channel  (result.last_channel)
    );

endmodule

// ===== src/sfd_checker.sv =====
// Port-level checker of the S.BUS frame decoder, bound to the top level.
// Depends on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module sfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_valid,
    input logic        rx_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [3:0]  res_index,
    input logic [11:0] res_value,
    input logic        res_last
);

    // A byte is never taken while a decoded result is on offer.
    `SFD_ASSERT_SAME(a_no_rx_during_emit, clk, rst_n, rx_valid && rx_ready, !res_valid)

    // A stalled result holds its payload.
    `SFD_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(res_index) && $stable(res_value) && $stable(res_last))

    // Channels of a frame follow each other without a gap, in order.
    `SFD_ASSERT_NEXT(a_chan_step, clk, rst_n, res_valid && res_ready && !res_last,
        res_valid && (res_index == $past(res_index) + 4'd1))

    // The final channel closes the frame.
    `SFD_ASSERT_NEXT(a_frame_end, clk, rst_n, res_valid && res_ready && res_last, !res_valid)

endmodule

bind sbus_frame_decoder_core sfd_checker u_sfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_index (result.channel_index),
    .res_value (result.channel_value),
    .res_last  (result.last_channel)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for sbus_frame_decoder_core: directed frames, then random traffic.
// Depends on sfd_pkg and on the sfd_rx_if, sfd_res_if and sfd_cfg_if interfaces of the RTL.
module tb_top
    import sfd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH      = 16;
    localparam int NUM_OFS     = 4;
    // Cycles allowed after the last decoded channel before the block counts as idle.
    // This covers the window check that follows a completing byte.
    localparam int SETTLE_CYCLES = 20;

    // One decoded channel as it should appear on the result channel.
    typedef struct packed {
        logic [3:0]  index;
        logic [11:0] value;
        logic        last;
    } chan_result_t;

    // How the channel bytes of a generated frame are filled.
    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_ONES,
        FILL_RANDOM
    } payload_fill_e;

    logic clk;
    logic rst_n;

    sfd_rx_if  rx ();
    sfd_res_if result ();
    sfd_cfg_if cfg ();

    sbus_frame_decoder_core #(
        .CHANNELS        (NUM_CH),
        .OFFSET_CHANNELS (NUM_OFS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .result (result),
        .cfg    (cfg)
    );

    // Shadow of the decoder: byte window, fill level and the four registers.
    byte_t            rx_window [FRAME_LEN];
    int unsigned      fill_level;
    byte_t            header_req;
    byte_t            marker_req;
    byte_t            drop_mask;
    logic [10:0]      centre_ofs;

    // Decoded channels still waiting to come out of the block, oldest first.
    chan_result_t     expected_channels [$];
    bit               failed;

    // Bytes left in the current burst of the byte sender.
    int               burst_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Absolute limit on the run.
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Mirror one accepted byte into the shadow window. When the window fills,
    // the header and marker decide between a slide by one byte and a full
    // frame; a full frame whose flag byte meets the mask gives nothing, any
    // other gives one expected result per channel.
    function automatic void decode_byte(input byte_t b);
        logic [DATA_BITS-1:0] payload;
        logic [11:0]          val;
        chan_result_t         r;
        rx_window[fill_level] = b;
        fill_level++;
        if (fill_level < FRAME_LEN)
            return;
        if (rx_window[0] != header_req || rx_window[MARK_POS] != marker_req)
        begin
            for (int k = 0; k < SLIDE_LEN; k++)
                rx_window[k] = rx_window[k + 1];
            fill_level = SLIDE_LEN;
            return;
        end
        fill_level = 0;
        if ((rx_window[FLAG_POS] & drop_mask) != 8'h00)
            return;
        // Bytes 1 to 22 form one little-endian bit stream; channel ch starts at bit 11*ch.
        for (int k = 0; k < DATA_BYTES; k++)
            payload[8*k +: 8] = rx_window[k + 1];
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            val = {1'b0, payload[CHAN_BITS*ch +: CHAN_BITS]};
            if (ch < NUM_OFS)
                val = val - {1'b0, centre_ofs};
            r.index = 4'(ch);
            r.value = val;
            r.last  = (ch == NUM_CH - 1);
            expected_channels.push_back(r);
        end
    endfunction

    // Present one byte request, holding it until the block takes it. Bursts
    // of random length are separated by random gaps; about a quarter of the
    // bursts follow on with no gap at all.
    task automatic send_byte(input byte_t b);
        int pause;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (pause > 0)
            begin
                rx.valid <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
        burst_left--;
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        decode_byte(b);
    endtask

    // A complete 25-byte frame: header, 21 channel bytes, marker, flags and a trailing byte.
    // The marker byte also carries the top bits of the last channel.
    task automatic send_frame(input byte_t hdr, input byte_t mark, input byte_t flags,
                              input payload_fill_e fill);
        byte_t d;
        send_byte(hdr);
        for (int k = 1; k < MARK_POS; k++)
        begin
            case (fill)
                FILL_ZERO: d = 8'h00;
                FILL_ONES: d = 8'hFF;
                default:   d = byte_t'($urandom_range(0, 255));
            endcase
            send_byte(d);
        end
        send_byte(mark);
        send_byte(flags);
        send_byte(byte_t'($urandom_range(0, 255)));
    endtask

    // Stop sending and wait until every decoded channel has come out, then
    // give the block time to finish a window check that produces nothing.
    task automatic wait_idle();
        rx.valid <= 1'b0;
        burst_left = 0;
        while (expected_channels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write request; the shadow register takes the low bits on acceptance.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_HEADER: header_req = value[7:0];
            REG_MARKER: marker_req = value[7:0];
            REG_FLAGS:  drop_mask  = value[7:0];
            REG_OFFSET: centre_ofs = value;
        endcase
    endtask

    // Write all four registers back to back. Callers make sure the block is idle first.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] hdr,
                                input logic [CFG_DATA_W-1:0] mark,
                                input logic [CFG_DATA_W-1:0] mask,
                                input logic [CFG_DATA_W-1:0] offset);
        write_reg(REG_HEADER, hdr);
        write_reg(REG_MARKER, mark);
        write_reg(REG_FLAGS, mask);
        write_reg(REG_OFFSET, offset);
        cfg.valid <= 1'b0;
    endtask

    // Registers straight out of reset: full-scale and zero channel data, with flag
    // bits clear or set only outside the default mask so both frames are decoded.
    task automatic test_reset_defaults();
        send_frame(HEADER_RESET, MARKER_RESET, 8'h00, FILL_ONES);
        send_frame(HEADER_RESET, MARKER_RESET, 8'hCF, FILL_ZERO);
    endtask

    // A flag byte that meets the mask drops the frame; the next frame decodes normally.
    task automatic test_dropped_frame();
        send_frame(header_req, marker_req, 8'h20, FILL_RANDOM);
        send_frame(header_req, marker_req, 8'h00, FILL_RANDOM);
    endtask

    // Stray bytes ahead of a frame, and a frame with a bad marker, both force
    // the window to slide until the header and marker line up again.
    task automatic test_realignment();
        send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_frame(header_req, marker_req, 8'h00, FILL_RANDOM);
        send_frame(header_req, marker_req ^ 8'h01, 8'h00, FILL_RANDOM);
        send_frame(header_req, marker_req, 8'h00, FILL_RANDOM);
    endtask

    // Register extremes. The first header and marker writes carry bits above
    // bit 7, which the block must discard. That setting gives the most negative
    // offset channels, the second the largest positive ones and drops any
    // frame with a flag bit set.
    task automatic test_register_extremes();
        wait_idle();
        program_regs(11'h7FF, 11'h700, 11'h000, 11'h7FF);
        send_frame(8'hFF, 8'h00, 8'hFF, FILL_ZERO);
        wait_idle();
        program_regs(11'h000, 11'h0FF, 11'h0FF, 11'h000);
        send_frame(8'h00, 8'hFF, 8'h00, FILL_ONES);
        send_frame(8'h00, 8'hFF, 8'h01, FILL_ONES);
    endtask

    // Random traffic under the current registers until about byte_budget bytes
    // have gone in. Most of it is well-formed frames with random content; the
    // rest is line noise, cut-off frames and frames with a broken marker.
    task automatic random_phase(input int byte_budget);
        int    sent_goal;
        int    pick;
        int    cut;
        byte_t flags;
        sent_goal = byte_budget;
        while (sent_goal > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                flags = byte_t'($urandom_range(0, 255));
                if ($urandom_range(0, 3) != 0)
                    flags = flags & ~drop_mask;
                send_frame(header_req, marker_req, flags, FILL_RANDOM);
                sent_goal -= FRAME_LEN;
            end
            else if (pick < 80)
            begin
                cut = $urandom_range(1, 4);
                repeat (cut) send_byte(byte_t'($urandom_range(0, 255)));
                sent_goal -= cut;
            end
            else if (pick < 90)
            begin
                cut = $urandom_range(1, FRAME_LEN - 2);
                send_byte(header_req);
                repeat (cut) send_byte(byte_t'($urandom_range(0, 255)));
                sent_goal -= cut + 1;
            end
            else
            begin
                send_frame(header_req, marker_req ^ byte_t'(1 << $urandom_range(0, 7)),
                           8'h00, FILL_RANDOM);
                sent_goal -= FRAME_LEN;
            end
            // Now and then hold the sender until the decoder has drained.
            if ($urandom_range(0, 19) == 0)
                wait_idle();
        end
    endtask

    // Random phases under several register settings, one with the default header, marker and mask.
    task automatic test_random_traffic();
        wait_idle();
        program_regs(11'(HEADER_RESET), 11'(MARKER_RESET), 11'(FLAGS_RESET), 11'd1024);
        random_phase(10);
        wait_idle();
        program_regs(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                     11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
        random_phase(10);
        wait_idle();
        program_regs(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                     11'h000, 11'($urandom_range(0, 2047)));
        random_phase(10);
    endtask

    // Result side: ready follows a pattern that changes after each run of random length:
    // always ready, coin flips, mostly ready, or a long hold-off.
    initial
    begin
        int mode;
        int run;
        result.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            run  = (mode == 3) ? $urandom_range(4, 20) : $urandom_range(8, 60);
            repeat (run)
            begin
                @(posedge clk);
                case (mode)
                    0:       result.ready <= 1'b1;
                    1:       result.ready <= 1'($urandom_range(0, 1));
                    2:       result.ready <= ($urandom_range(0, 7) != 0);
                    default: result.ready <= 1'b0;
                endcase
            end
        end
    end

    // Each accepted result request is matched against the oldest expected channel.
    always @(posedge clk)
    begin : result_check
        chan_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_channels.size() == 0)
            begin
                $error("result with nothing expected: channel_index %0d channel_value %0d",
                       result.channel_index, result.channel_value);
                failed = 1'b1;
            end
            else
            begin
                want = expected_channels.pop_front();
                if (result.channel_index !== want.index)
                begin
                    $error("channel_index: expected %0d, actual %0d",
                           want.index, result.channel_index);
                    failed = 1'b1;
                end
                if (result.channel_value !== want.value)
                begin
                    $error("channel_value: expected %0d, actual %0d",
                           $signed(want.value), result.channel_value);
                    failed = 1'b1;
                end
                if (result.last_channel !== want.last)
                begin
                    $error("last_channel: expected %0d, actual %0d",
                           want.last, result.last_channel);
                    failed = 1'b1;
                end
            end
        end
    end

    // Main sequence: reset once, then each test in turn, then drain and report.
    initial
    begin
        failed      = 1'b0;
        burst_left  = 0;
        fill_level  = 0;
        header_req  = HEADER_RESET;
        marker_req  = MARKER_RESET;
        drop_mask   = FLAGS_RESET;
        centre_ofs  = OFFSET_RESET;
        rst_n       = 1'b0;
        rx.valid    = 1'b0;
        rx.rx_byte  = 8'h00;
        cfg.valid   = 1'b0;
        cfg.index   = REG_HEADER;
        cfg.data    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_dropped_frame();
        test_realignment();
        test_register_extremes();
        test_random_traffic();

        wait_idle();
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
